// ===== hw/rtl/pfp_pkg.sv =====
// Shared constants and control types of the proportional-fair user picker.
package pfp_pkg;

   localparam int NUM_USERS_DEF          = 8;
   localparam int RATE_FRACTION_BITS_DEF = 16;
   localparam int RATE_BITS              = 32;
   localparam int WINDOW_BITS            = 16;
   localparam int USER_FIELD_BITS        = 3;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 16'd100;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic shift;
      logic div_start;
      logic div_step;
      logic commit;
   } cell_ctl_type;

   typedef struct packed {
      logic clear;
      logic mul;
      logic sum;
      logic decide;
   } cmp_ctl_type;

endpackage

// ===== hw/rtl/proportional_fair_user_picker.sv =====
// Top level of the proportional-fair user picker: a ring of user cells.
// A load beat is written into its cell on acceptance. A tick beat visits each user in turn
// with multiply, sum and compare steps in the shared compare unit while the ring rotates,
// then runs the per-cell bit-serial dividers before the result is committed and offered.
// One beat is worked on at a time; loads are taken while a result waits.
// Synchronous reset clears all means, rates, eligibility and sets the window to 100.
module proportional_fair_user_picker #(
   parameter int NUM_USERS          = pfp_pkg::NUM_USERS_DEF,
   parameter int RATE_FRACTION_BITS = pfp_pkg::RATE_FRACTION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // user_index[2:0], rate[34:3], eligible[35], zero
   input  logic        req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // granted_user[2:0], zero
   output logic        rsp_tuser,  // grant_valid
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [pfp_pkg::WINDOW_BITS-1:0] csr_data
);
   import pfp_pkg::*;

   localparam int MEAN_BITS = RATE_BITS + RATE_FRACTION_BITS;
   localparam int IDX_BITS  = $clog2(NUM_USERS);
   localparam int DCNT_BITS = $clog2(MEAN_BITS + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MUL    = 3'd1;
   localparam logic [2:0] S_SUM    = 3'd2;
   localparam logic [2:0] S_CMP    = 3'd3;
   localparam logic [2:0] S_DSTART = 3'd4;
   localparam logic [2:0] S_DIV    = 3'd5;
   localparam logic [2:0] S_COMMIT = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic [IDX_BITS-1:0]    ucnt_ff, ucnt_in;
   logic [DCNT_BITS-1:0]   dcnt_ff, dcnt_in;
   logic [WINDOW_BITS-1:0] win_ff, win_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_grant_ff, rsp_grant_in;
   logic [2:0]             rsp_user_ff, rsp_user_in;

   logic                   req_fire, load_fire, tick_fire;
   logic [2:0]             ld_idx;
   logic [RATE_BITS-1:0]   ld_rate;
   logic                   ld_elig;
   logic [WINDOW_BITS-1:0] divisor;
   cell_ctl_type           cctl;
   cmp_ctl_type            kctl;

   logic [RATE_BITS-1:0]   c_rate [NUM_USERS];
   logic                   c_elig [NUM_USERS];
   logic [MEAN_BITS-1:0]   c_mean [NUM_USERS];

   logic                   found;
   logic [IDX_BITS-1:0]    best_idx;
   logic [RATE_BITS-1:0]   best_rate;
   logic [MEAN_BITS-1:0]   win_quot;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load_fire  = req_fire && (req_tuser == OP_LOAD);
   assign tick_fire  = req_fire && (req_tuser == OP_TICK);
   assign ld_idx     = req_tdata[2:0];
   assign ld_rate    = req_tdata[34:3];
   assign ld_elig    = req_tdata[35];
   assign divisor    = (win_ff == '0) ? WINDOW_BITS'(1) : win_ff;
   assign csr_ready  = 1'b1;

   always_comb begin
      cctl.shift     = (state_ff == S_CMP);
      cctl.div_start = (state_ff == S_DSTART);
      cctl.div_step  = (state_ff == S_DIV);
      cctl.commit    = (state_ff == S_COMMIT);
      kctl.clear     = tick_fire;
      kctl.mul       = (state_ff == S_MUL);
      kctl.sum       = (state_ff == S_SUM);
      kctl.decide    = (state_ff == S_CMP);
   end

   for (genvar j = 0; j < NUM_USERS; j++) begin : g_cell
      localparam int NXT = (j + 1) % NUM_USERS;
      logic                 sel;
      logic [MEAN_BITS-1:0] add_value;
      assign sel = load_fire && ({29'd0, ld_idx} == 32'(j));
      assign add_value = (found && (best_idx == IDX_BITS'(j))) ? win_quot : '0;
      pfp_cell #(.MEAN_BITS(MEAN_BITS)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cctl),
         .sel        (sel),
         .load_rate  (ld_rate),
         .load_elig  (ld_elig),
         .divisor    (divisor),
         .add_value  (add_value),
         .shift_rate (c_rate[NXT]),
         .shift_elig (c_elig[NXT]),
         .shift_mean (c_mean[NXT]),
         .rate       (c_rate[j]),
         .elig       (c_elig[j]),
         .mean       (c_mean[j])
      );
   end

   pfp_cmp #(.MEAN_BITS(MEAN_BITS), .IDX_BITS(IDX_BITS)) u_cmp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (kctl),
      .head_rate (c_rate[0]),
      .head_mean (c_mean[0]),
      .head_elig (c_elig[0]),
      .head_idx  (ucnt_ff),
      .found     (found),
      .best_idx  (best_idx),
      .best_rate (best_rate)
   );

   pfp_div #(.WIDTH(MEAN_BITS)) u_win_div (
      .clock    (clock),
      .start    (cctl.div_start),
      .step     (cctl.div_step),
      .dividend (MEAN_BITS'(best_rate) << RATE_FRACTION_BITS),
      .divisor  (divisor),
      .quotient (win_quot)
   );

   always_comb begin
      state_in     = state_ff;
      ucnt_in      = ucnt_ff;
      dcnt_in      = dcnt_ff;
      win_in       = csr_valid ? csr_data : win_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_grant_in = rsp_grant_ff;
      rsp_user_in  = rsp_user_ff;
      case (state_ff)
         S_IDLE: begin
            if (tick_fire) begin
               state_in = S_MUL;
               ucnt_in  = '0;
            end
         end
         S_MUL: state_in = S_SUM;
         S_SUM: state_in = S_CMP;
         S_CMP: begin
            if (ucnt_ff == IDX_BITS'(NUM_USERS - 1)) begin
               state_in = S_DSTART;
               ucnt_in  = '0;
            end else begin
               state_in = S_MUL;
               ucnt_in  = ucnt_ff + 1'b1;
            end
         end
         S_DSTART: begin
            state_in = S_DIV;
            dcnt_in  = '0;
         end
         S_DIV: begin
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_BITS'(MEAN_BITS - 1)) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: state_in = S_OUT;
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_grant_in = found;
               rsp_user_in  = found ? 3'(best_idx) : 3'd0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ucnt_ff      <= '0;
         dcnt_ff      <= '0;
         win_ff       <= WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ucnt_ff      <= ucnt_in;
         dcnt_ff      <= dcnt_in;
         win_ff       <= win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_grant_ff <= rsp_grant_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_grant_ff;
   assign rsp_tdata  = {5'd0, rsp_user_ff};

   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      tick_fire |=> (state_ff == S_MUL) && (ucnt_ff == '0))
      else $error("tick did not start the compare walk");

   a_ring_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DSTART) |-> (ucnt_ff == '0) && $past(state_ff == S_CMP))
      else $error("ring not realigned before division");

   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == S_OUT))
      else $error("result raised outside output step");

   a_no_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_grant_ff) |-> (rsp_user_ff == 3'd0))
      else $error("user index set without a grant");

endmodule

// ===== hw/rtl/pfp_div.sv =====
// Bit-serial restoring divider by the averaging window.
module pfp_div #(
   parameter int WIDTH = 48
) (
   input  logic                                clock,
   input  logic                                start,
   input  logic                                step,
   input  logic [WIDTH-1:0]                    dividend,
   input  logic [pfp_pkg::WINDOW_BITS-1:0]     divisor,
   output logic [WIDTH-1:0]                    quotient
);
   import pfp_pkg::*;

   logic [WIDTH-1:0]       dvd_ff, dvd_in;
   logic [WINDOW_BITS-1:0] rem_ff, rem_in;
   logic [WINDOW_BITS:0]   trial;

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      trial  = {rem_ff, dvd_ff[WIDTH-1]};
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
      end else if (step) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = WINDOW_BITS'(trial - {1'b0, divisor});
            dvd_in = {dvd_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[WINDOW_BITS-1:0];
            dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign quotient = dvd_ff;

endmodule

// ===== hw/rtl/pfp_cell.sv =====
// One user cell: rate, eligibility and mean served rate, with its own divider.
module pfp_cell #(
   parameter int MEAN_BITS = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pfp_pkg::cell_ctl_type               ctl,
   input  logic                                sel,
   input  logic [pfp_pkg::RATE_BITS-1:0]       load_rate,
   input  logic                                load_elig,
   input  logic [pfp_pkg::WINDOW_BITS-1:0]     divisor,
   input  logic [MEAN_BITS-1:0]                add_value,
   input  logic [pfp_pkg::RATE_BITS-1:0]       shift_rate,
   input  logic                                shift_elig,
   input  logic [MEAN_BITS-1:0]                shift_mean,
   output logic [pfp_pkg::RATE_BITS-1:0]       rate,
   output logic                                elig,
   output logic [MEAN_BITS-1:0]                mean
);
   import pfp_pkg::*;

   logic [RATE_BITS-1:0] rate_ff, rate_in;
   logic                 elig_ff, elig_in;
   logic [MEAN_BITS-1:0] mean_ff, mean_in;
   logic [MEAN_BITS-1:0] quot;
   logic [MEAN_BITS-1:0] decayed;
   logic [MEAN_BITS:0]   total;

   pfp_div #(.WIDTH(MEAN_BITS)) u_div (
      .clock    (clock),
      .start    (ctl.div_start),
      .step     (ctl.div_step),
      .dividend (mean_ff),
      .divisor  (divisor),
      .quotient (quot)
   );

   always_comb begin
      rate_in = rate_ff;
      elig_in = elig_ff;
      mean_in = mean_ff;
      decayed = mean_ff - quot;
      total   = {1'b0, decayed} + {1'b0, add_value};
      if (ctl.shift) begin
         rate_in = shift_rate;
         elig_in = shift_elig;
         mean_in = shift_mean;
      end else if (ctl.commit) begin
         mean_in = total[MEAN_BITS] ? '1 : total[MEAN_BITS-1:0];
      end else if (sel) begin
         rate_in = load_rate;
         elig_in = load_elig;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= '0;
         elig_ff <= 1'b0;
         mean_ff <= '0;
      end else begin
         rate_ff <= rate_in;
         elig_ff <= elig_in;
         mean_ff <= mean_in;
      end
   end

   assign rate = rate_ff;
   assign elig = elig_ff;
   assign mean = mean_ff;

endmodule

// ===== hw/rtl/pfp_cmp.sv =====
// Running argmax of rate over mean by cross-multiplication, one user per step.
module pfp_cmp #(
   parameter int MEAN_BITS = 48,
   parameter int IDX_BITS  = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pfp_pkg::cmp_ctl_type                ctl,
   input  logic [pfp_pkg::RATE_BITS-1:0]       head_rate,
   input  logic [MEAN_BITS-1:0]                head_mean,
   input  logic                                head_elig,
   input  logic [IDX_BITS-1:0]                 head_idx,
   output logic                                found,
   output logic [IDX_BITS-1:0]                 best_idx,
   output logic [pfp_pkg::RATE_BITS-1:0]       best_rate
);
   import pfp_pkg::*;

   localparam int HB = (MEAN_BITS > 32) ? MEAN_BITS - 32 : 1;
   localparam int MX = 32 + HB;
   localparam int PW = RATE_BITS + MX;

   logic                 found_ff, found_in;
   logic [IDX_BITS-1:0]  idx_ff, idx_in;
   logic [RATE_BITS-1:0] brate_ff, brate_in;
   logic [MEAN_BITS-1:0] bmean_ff, bmean_in;
   logic [MX-1:0]        bm_x, hm_x;
   logic [63:0]          pl_ff, ql_ff;
   logic [RATE_BITS+HB-1:0] ph_ff, qh_ff;
   logic [PW-1:0]        left_ff, right_ff;
   logic                 take;

   assign bm_x = MX'(bmean_ff);
   assign hm_x = MX'(head_mean);

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         pl_ff <= head_rate * bm_x[31:0];
         ph_ff <= head_rate * bm_x[MX-1:32];
         ql_ff <= brate_ff * hm_x[31:0];
         qh_ff <= brate_ff * hm_x[MX-1:32];
      end
      if (ctl.sum) begin
         left_ff  <= PW'(pl_ff) + (PW'(ph_ff) << 32);
         right_ff <= PW'(ql_ff) + (PW'(qh_ff) << 32);
      end
   end

   always_comb begin
      found_in = found_ff;
      idx_in   = idx_ff;
      brate_in = brate_ff;
      bmean_in = bmean_ff;
      take     = 1'b0;
      if (head_elig) begin
         if (!found_ff) begin
            take = 1'b1;
         end else if (bmean_ff != '0) begin
            take = (head_mean == '0) || (left_ff > right_ff);
         end
      end
      if (ctl.clear) begin
         found_in = 1'b0;
         idx_in   = '0;
      end else if (ctl.decide && take) begin
         found_in = 1'b1;
         idx_in   = head_idx;
         brate_in = head_rate;
         bmean_in = head_mean;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         found_ff <= found_in;
         idx_ff   <= idx_in;
      end
      brate_ff <= brate_in;
      bmean_ff <= bmean_in;
   end

   assign found     = found_ff;
   assign best_idx  = idx_ff;
   assign best_rate = brate_ff;

endmodule

// ===== tb/tb_proportional_fair_user_picker.sv =====
// Self-checking testbench of the proportional-fair user picker: directed and random load and tick beats.
`timescale 1ns / 1ps

module tb_proportional_fair_user_picker;
   import pfp_pkg::*;

   localparam int NU = 8;
   localparam int FB = 16;
   localparam int LATENCY = 3 * NU + 32 + FB + 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [WINDOW_BITS-1:0] csr_data = '0;

   typedef struct packed {
      logic       granted;
      logic [2:0] user;
   } grant_type;

   logic [47:0] mean_q [NU];
   logic [31:0] rate_q [NU];
   logic        elig_q [NU];
   logic [15:0] window_q;
   grant_type   grant_queue [$];
   int          errors = 0;
   bit          rsp_stall_on = 1'b1;
   bit          req_gap_on = 1'b1;

   proportional_fair_user_picker u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // predict the grant of one tick and advance the means
   function automatic grant_type pick_and_decay();
      grant_type   g;
      logic        found;
      int          best;
      logic [79:0] lhs, rhs;
      logic [63:0] w, m;
      found = 1'b0;
      best = 0;
      for (int i = 0; i < NU; i++) begin
         if (elig_q[i]) begin
            if (!found) begin
               found = 1'b1;
               best = i;
            end else if (mean_q[best] != 0) begin
               lhs = 80'(rate_q[i]) * 80'(mean_q[best]);
               rhs = 80'(rate_q[best]) * 80'(mean_q[i]);
               if (mean_q[i] == 0 || lhs > rhs) best = i;
            end
         end
      end
      w = (window_q == 0) ? 64'd1 : 64'(window_q);
      for (int i = 0; i < NU; i++) begin
         m = 64'(mean_q[i]);
         m = m - m / w;
         if (found && i == best) m = m + ((64'(rate_q[i]) << FB) / w);
         if (m > 64'hFFFF_FFFF_FFFF) m = 64'hFFFF_FFFF_FFFF;
         mean_q[i] = m[47:0];
      end
      g.granted = found;
      g.user = found ? best[2:0] : 3'd0;
      return g;
   endfunction

   task automatic send_beat(input logic op, input logic [2:0] idx,
                            input logic [31:0] rate, input logic elig);
      if (req_gap_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, elig, rate, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_LOAD) begin
         rate_q[idx] = rate;
         elig_q[idx] = elig;
      end else begin
         grant_queue.insert(grant_queue.size(), pick_and_decay());
      end
      @(negedge clock);
   endtask

   task automatic write_window(input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (grant_queue.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      window_q = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (rsp_stall_on && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      grant_type g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (grant_queue.size() == 0) begin
            $error("unexpected grant beat");
            errors++;
         end else begin
            g = grant_queue.pop_front();
            if (rsp_tuser !== g.granted) begin
               $error("grant_valid expected %0d actual %0d", g.granted, rsp_tuser);
               errors++;
            end
            if (rsp_tdata !== {5'd0, g.user}) begin
               $error("granted_user expected %0d actual %0d", g.user, rsp_tdata);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      send_beat(OP_TICK, 3'd0, 32'd0, 1'b0);
      send_beat(OP_LOAD, 3'd5, 32'd0, 1'b1);
      send_beat(OP_LOAD, 3'd2, 32'd0, 1'b1);
      send_beat(OP_TICK, 3'd7, 32'hFFFF_FFFF, 1'b1);
      send_beat(OP_LOAD, 3'd7, 32'hFFFF_FFFF, 1'b1);
      send_beat(OP_LOAD, 3'd0, 32'hFFFF_FFFF, 1'b1);
      for (int i = 0; i < 6; i++) send_beat(OP_TICK, 3'd0, 32'd0, 1'b0);
      for (int i = 0; i < NU; i++) send_beat(OP_LOAD, i[2:0], 32'd1000, 1'b1);
      send_beat(OP_TICK, 3'd0, 32'd0, 1'b0);
      send_beat(OP_TICK, 3'd0, 32'd0, 1'b0);
   endtask

   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0)
            send_beat(OP_TICK, 3'($urandom), $urandom, 1'($urandom));
         else
            send_beat(OP_LOAD, 3'($urandom),
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000),
                      ($urandom_range(0, 4) != 0));
      end
   endtask

   task automatic test_windows();
      write_window(16'd1);
      test_random(250);
      write_window(16'd65535);
      test_random(250);
      write_window(16'd0);
      test_random(100);
      write_window(16'd7);
      test_random(250);
      write_window(16'($urandom_range(1, 65535)));
      test_random(250);
   endtask

   initial begin
      for (int i = 0; i < NU; i++) begin
         mean_q[i] = '0;
         rate_q[i] = '0;
         elig_q[i] = 1'b0;
      end
      window_q = WINDOW_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(150);
      test_windows();
      rsp_stall_on = 1'b0;
      req_gap_on = 1'b0;
      test_random(250);
      req_tvalid <= 1'b0;
      while (grant_queue.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
